// ----- design/uer_pkg.sv -----
// Shared types, constants and the control store of the ultrasonic echo ranger.
package uer_pkg;

  localparam int SAMPLES_DEF = 3;

  localparam int DIST_W     = 15;
  localparam int STATUS_W   = 2;
  localparam int TICK_W     = 24;
  localparam int TRIG_W     = 16;
  localparam int TPC_W      = 8;
  localparam int GAP_W      = 20;
  localparam int ECHO_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int PC_W       = 5;

  // cm = count * 34 / 100, as count * (34 * ceil(2^29 / 100)) >> 29; exact for 16-bit counts
  localparam int               CM_MUL_W = 28;
  localparam logic [CM_MUL_W-1:0] CM_MUL = 28'd182536140;
  localparam int               CM_SHIFT = 29;
  localparam int               PROD_W   = ECHO_W + CM_MUL_W;

  localparam logic [TRIG_W-1:0] TRIG_RST    = 16'd40;
  localparam logic [TPC_W-1:0]  TPC_RST     = 8'd20;
  localparam logic [TICK_W-1:0] TIMEOUT_RST = 24'd1000000;
  localparam logic [GAP_W-1:0]  GAP_RST     = 20'd10000;
  localparam logic [DIST_W-1:0] MIN_RST     = 15'd2;
  localparam logic [DIST_W-1:0] MAX_RST     = 15'd490;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIG_TICKS      = 3'd0,
    CFG_TICKS_PER_COUNT = 3'd1,
    CFG_TIMEOUT_TICKS   = 3'd2,
    CFG_GAP_TICKS       = 3'd3,
    CFG_MIN_DISTANCE    = 3'd4,
    CFG_MAX_DISTANCE    = 3'd5
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_ECHO  = 2'd1,
    STAT_STUCK    = 2'd2,
    STAT_NO_VALID = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TICK_HOLD,
    TICK_CLR,
    TICK_INC
  } tick_op_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_LOAD,
    DIV_STEP
  } div_op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_CMD,
    C_ECHO,
    C_NO_ECHO,
    C_TRIG_END,
    C_TIMEOUT,
    C_GAP_ZERO,
    C_GAP_END,
    C_LAST_ROUND,
    C_NO_VALID,
    C_DIV_MORE
  } cond_e;

  typedef struct packed {
    logic [TRIG_W-1:0] trig_ticks;
    logic [TPC_W-1:0]  ticks_per_count;
    logic [TICK_W-1:0] timeout_ticks;
    logic [GAP_W-1:0]  gap_ticks;
    logic [DIST_W-1:0] min_distance;
    logic [DIST_W-1:0] max_distance;
  } cfg_t;

  typedef struct packed {
    logic            fetch;
    logic            emit;
    logic            out_trig;
    logic            out_busy;
    logic            out_done;
    status_e         out_status;
    logic            out_dist;
    tick_op_e        tick_op;
    logic            run_clr;
    logic            meas_clr;
    logic            pre_tick;
    logic            mul_load;
    logic            acc_sample;
    logic            round_inc;
    div_op_e         div_op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic cmd;
    logic echo;
    logic trig_end;
    logic timeout;
    logic gap_zero;
    logic gap_end;
    logic last_round;
    logic no_valid;
    logic div_more;
    logic hold;
  } flags_t;

  localparam logic [PC_W-1:0] S_IDLE_F     = 5'd0;
  localparam logic [PC_W-1:0] S_IDLE       = 5'd1;
  localparam logic [PC_W-1:0] S_IDLE_OUT   = 5'd2;
  localparam logic [PC_W-1:0] S_START      = 5'd3;
  localparam logic [PC_W-1:0] S_TRIG       = 5'd4;
  localparam logic [PC_W-1:0] S_TRIG_OUT   = 5'd5;
  localparam logic [PC_W-1:0] S_TRIG_F     = 5'd6;
  localparam logic [PC_W-1:0] S_TRIG_LAST  = 5'd7;
  localparam logic [PC_W-1:0] S_RISE_F     = 5'd8;
  localparam logic [PC_W-1:0] S_RISE       = 5'd9;
  localparam logic [PC_W-1:0] S_RISE_WAIT  = 5'd10;
  localparam logic [PC_W-1:0] S_RISE_OUT   = 5'd11;
  localparam logic [PC_W-1:0] S_MEAS_START = 5'd12;
  localparam logic [PC_W-1:0] S_MEAS_F     = 5'd13;
  localparam logic [PC_W-1:0] S_MEAS       = 5'd14;
  localparam logic [PC_W-1:0] S_MEAS_HIGH  = 5'd15;
  localparam logic [PC_W-1:0] S_MEAS_OUT   = 5'd16;
  localparam logic [PC_W-1:0] S_CONV       = 5'd17;
  localparam logic [PC_W-1:0] S_ACC        = 5'd18;
  localparam logic [PC_W-1:0] S_ACC_OUT    = 5'd19;
  localparam logic [PC_W-1:0] S_GAP_F      = 5'd20;
  localparam logic [PC_W-1:0] S_GAP        = 5'd21;
  localparam logic [PC_W-1:0] S_GAP_OUT    = 5'd22;
  localparam logic [PC_W-1:0] S_ROUND_END  = 5'd23;
  localparam logic [PC_W-1:0] S_ROUND_OUT  = 5'd24;
  localparam logic [PC_W-1:0] S_FINAL      = 5'd25;
  localparam logic [PC_W-1:0] S_DIV_LOAD   = 5'd26;
  localparam logic [PC_W-1:0] S_DIV_STEP   = 5'd27;
  localparam logic [PC_W-1:0] S_DONE_OK    = 5'd28;
  localparam logic [PC_W-1:0] S_ERR_RISE   = 5'd29;
  localparam logic [PC_W-1:0] S_ERR_STUCK  = 5'd30;
  localparam logic [PC_W-1:0] S_ERR_NONE   = 5'd31;

  // Control store: one word per step; jump taken when cond holds, else fall through.
  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    cw = ctrl_word_t'(0);
    case (pc)
      S_IDLE_F: begin
        cw.fetch = 1'b1;
      end
      S_IDLE: begin
        cw.cond   = C_CMD;
        cw.target = S_START;
      end
      S_IDLE_OUT: begin
        cw.emit   = 1'b1;
        cw.cond   = C_ALWAYS;
        cw.target = S_IDLE_F;
      end
      S_START: begin
        cw.tick_op  = TICK_CLR;
        cw.run_clr  = 1'b1;
        cw.meas_clr = 1'b1;
      end
      S_TRIG: begin
        cw.tick_op = TICK_INC;
        cw.cond    = C_TRIG_END;
        cw.target  = S_TRIG_LAST;
      end
      S_TRIG_OUT: begin
        cw.emit     = 1'b1;
        cw.out_trig = 1'b1;
        cw.out_busy = 1'b1;
      end
      S_TRIG_F: begin
        cw.fetch  = 1'b1;
        cw.cond   = C_ALWAYS;
        cw.target = S_TRIG;
      end
      S_TRIG_LAST: begin
        cw.tick_op  = TICK_CLR;
        cw.emit     = 1'b1;
        cw.out_trig = 1'b1;
        cw.out_busy = 1'b1;
      end
      S_RISE_F: begin
        cw.fetch = 1'b1;
      end
      S_RISE: begin
        cw.cond   = C_ECHO;
        cw.target = S_MEAS_START;
      end
      S_RISE_WAIT: begin
        cw.tick_op = TICK_INC;
        cw.cond    = C_TIMEOUT;
        cw.target  = S_ERR_RISE;
      end
      S_RISE_OUT: begin
        cw.emit     = 1'b1;
        cw.out_busy = 1'b1;
        cw.cond     = C_ALWAYS;
        cw.target   = S_RISE_F;
      end
      S_MEAS_START: begin
        cw.tick_op  = TICK_CLR;
        cw.meas_clr = 1'b1;
        cw.emit     = 1'b1;
        cw.out_busy = 1'b1;
      end
      S_MEAS_F: begin
        cw.fetch = 1'b1;
      end
      S_MEAS: begin
        cw.cond   = C_NO_ECHO;
        cw.target = S_CONV;
      end
      S_MEAS_HIGH: begin
        cw.tick_op  = TICK_INC;
        cw.pre_tick = 1'b1;
        cw.cond     = C_TIMEOUT;
        cw.target   = S_ERR_STUCK;
      end
      S_MEAS_OUT: begin
        cw.emit     = 1'b1;
        cw.out_busy = 1'b1;
        cw.cond     = C_ALWAYS;
        cw.target   = S_MEAS_F;
      end
      S_CONV: begin
        cw.tick_op  = TICK_CLR;
        cw.mul_load = 1'b1;
      end
      S_ACC: begin
        cw.acc_sample = 1'b1;
        cw.cond       = C_GAP_ZERO;
        cw.target     = S_ROUND_END;
      end
      S_ACC_OUT: begin
        cw.emit     = 1'b1;
        cw.out_busy = 1'b1;
      end
      S_GAP_F: begin
        cw.fetch = 1'b1;
      end
      S_GAP: begin
        cw.tick_op = TICK_INC;
        cw.cond    = C_GAP_END;
        cw.target  = S_ROUND_END;
      end
      S_GAP_OUT: begin
        cw.emit     = 1'b1;
        cw.out_busy = 1'b1;
        cw.cond     = C_ALWAYS;
        cw.target   = S_GAP_F;
      end
      S_ROUND_END: begin
        cw.tick_op   = TICK_CLR;
        cw.round_inc = 1'b1;
        cw.cond      = C_LAST_ROUND;
        cw.target    = S_FINAL;
      end
      S_ROUND_OUT: begin
        cw.emit     = 1'b1;
        cw.out_busy = 1'b1;
        cw.cond     = C_ALWAYS;
        cw.target   = S_TRIG_F;
      end
      S_FINAL: begin
        cw.cond   = C_NO_VALID;
        cw.target = S_ERR_NONE;
      end
      S_DIV_LOAD: begin
        cw.div_op = DIV_LOAD;
      end
      S_DIV_STEP: begin
        cw.div_op = DIV_STEP;
        cw.cond   = C_DIV_MORE;
        cw.target = S_DIV_STEP;
      end
      S_DONE_OK: begin
        cw.emit       = 1'b1;
        cw.out_done   = 1'b1;
        cw.out_status = STAT_OK;
        cw.out_dist   = 1'b1;
        cw.cond       = C_ALWAYS;
        cw.target     = S_IDLE_F;
      end
      S_ERR_RISE: begin
        cw.emit       = 1'b1;
        cw.out_done   = 1'b1;
        cw.out_status = STAT_NO_ECHO;
        cw.cond       = C_ALWAYS;
        cw.target     = S_IDLE_F;
      end
      S_ERR_STUCK: begin
        cw.emit       = 1'b1;
        cw.out_done   = 1'b1;
        cw.out_status = STAT_STUCK;
        cw.cond       = C_ALWAYS;
        cw.target     = S_IDLE_F;
      end
      S_ERR_NONE: begin
        cw.emit       = 1'b1;
        cw.out_done   = 1'b1;
        cw.out_status = STAT_NO_VALID;
        cw.cond       = C_ALWAYS;
        cw.target     = S_IDLE_F;
      end
      default: begin
        cw.cond   = C_ALWAYS;
        cw.target = S_IDLE_F;
      end
    endcase
    return cw;
  endfunction

endpackage

// ----- design/uer_if.sv -----
// Channel interfaces: tick input, result output and register write port.
interface uer_tick_if;
  logic valid;
  logic ready;
  logic cmd;
  logic echo;
  modport source (output valid, cmd, echo, input ready);
  modport sink   (input valid, cmd, echo, output ready);
endinterface

interface uer_result_if;
  logic                         valid;
  logic                         ready;
  logic                         trigger;
  logic                         busy_res;
  logic                         done_res;
  logic [uer_pkg::DIST_W-1:0]   distance;
  logic [uer_pkg::STATUS_W-1:0] status;
  modport source (output valid, trigger, busy_res, done_res, distance, status, input ready);
  modport sink   (input valid, trigger, busy_res, done_res, distance, status, output ready);
endinterface

interface uer_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [uer_pkg::CFG_IDX_W-1:0]  index;
  logic [uer_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/uer_cfg_regs.sv -----
// Configuration register file with write port.
module uer_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  uer_cfg_if.sink       cfg,
  output uer_pkg::cfg_t regs
);

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.trig_ticks      <= uer_pkg::TRIG_RST;
      regs.ticks_per_count <= uer_pkg::TPC_RST;
      regs.timeout_ticks   <= uer_pkg::TIMEOUT_RST;
      regs.gap_ticks       <= uer_pkg::GAP_RST;
      regs.min_distance    <= uer_pkg::MIN_RST;
      regs.max_distance    <= uer_pkg::MAX_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        uer_pkg::CFG_TRIG_TICKS:      regs.trig_ticks      <= cfg.data[uer_pkg::TRIG_W-1:0];
        uer_pkg::CFG_TICKS_PER_COUNT: regs.ticks_per_count <= cfg.data[uer_pkg::TPC_W-1:0];
        uer_pkg::CFG_TIMEOUT_TICKS:   regs.timeout_ticks   <= cfg.data[uer_pkg::TICK_W-1:0];
        uer_pkg::CFG_GAP_TICKS:       regs.gap_ticks       <= cfg.data[uer_pkg::GAP_W-1:0];
        uer_pkg::CFG_MIN_DISTANCE:    regs.min_distance    <= cfg.data[uer_pkg::DIST_W-1:0];
        uer_pkg::CFG_MAX_DISTANCE:    regs.max_distance    <= cfg.data[uer_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/uer_seq.sv -----
// Microprogram sequencer: step counter, control store and jump logic.
module uer_seq (
  input  logic                clk,
  input  logic                rst,
  input  uer_pkg::flags_t     flags,
  output uer_pkg::ctrl_word_t cw
);

  logic [uer_pkg::PC_W-1:0] pc;
  logic [uer_pkg::PC_W-1:0] pc_next;
  logic                     jump;

  assign cw = uer_pkg::ucode(pc);

  always_comb begin
    case (cw.cond)
      uer_pkg::C_NEVER:      jump = 1'b0;
      uer_pkg::C_ALWAYS:     jump = 1'b1;
      uer_pkg::C_CMD:        jump = flags.cmd;
      uer_pkg::C_ECHO:       jump = flags.echo;
      uer_pkg::C_NO_ECHO:    jump = !flags.echo;
      uer_pkg::C_TRIG_END:   jump = flags.trig_end;
      uer_pkg::C_TIMEOUT:    jump = flags.timeout;
      uer_pkg::C_GAP_ZERO:   jump = flags.gap_zero;
      uer_pkg::C_GAP_END:    jump = flags.gap_end;
      uer_pkg::C_LAST_ROUND: jump = flags.last_round;
      uer_pkg::C_NO_VALID:   jump = flags.no_valid;
      uer_pkg::C_DIV_MORE:   jump = flags.div_more;
      default:               jump = 1'b0;
    endcase
  end

  always_comb begin
    if (flags.hold) begin
      pc_next = pc;
    end else if (jump) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + uer_pkg::PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= uer_pkg::S_IDLE_F;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ----- design/uer_divider.sv -----
// Restoring divider, one quotient bit per step, for the final average.
module uer_divider #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 2
) (
  input  logic               clk,
  input  uer_pkg::div_op_e   op,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  output logic [NUM_W-1:0]   quo,
  output logic               more
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   den_x;
  logic             ge;

  assign rem_sh = {rem, quo[NUM_W-1]};
  assign den_x  = {1'b0, den};
  assign ge     = rem_sh >= den_x;
  assign more   = cnt != CNT_W'(1);

  always_ff @(posedge clk) begin
    case (op)
      uer_pkg::DIV_LOAD: begin
        rem <= '0;
        quo <= num;
        cnt <= CNT_W'(NUM_W);
      end
      uer_pkg::DIV_STEP: begin
        rem <= ge ? DEN_W'(rem_sh - den_x) : DEN_W'(rem_sh);
        quo <= {quo[NUM_W-2:0], ge};
        cnt <= cnt - CNT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

// ----- design/uer_datapath.sv -----
// Datapath: counters, range conversion, accumulator, handshakes and result register.
module uer_datapath #(
  parameter int SAMPLES = uer_pkg::SAMPLES_DEF,
  parameter int SUM_W   = uer_pkg::DIST_W + $clog2(SAMPLES),
  parameter int RW      = $clog2(SAMPLES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  uer_pkg::cfg_t       regs,
  input  uer_pkg::ctrl_word_t cw,
  input  logic [SUM_W-1:0]    quo,
  input  logic                div_more,
  output uer_pkg::flags_t     flags,
  output logic [SUM_W-1:0]    sum,
  output logic [RW-1:0]       valid_cnt,
  uer_tick_if.sink            tick,
  uer_result_if.source        result
);

  localparam logic [RW:0] SAMPLES_V = (RW + 1)'(SAMPLES);

  logic                          cmd_q;
  logic                          echo_q;
  logic [uer_pkg::TICK_W-1:0]    tick_cnt;
  logic [uer_pkg::TPC_W-1:0]     pre_cnt;
  logic [uer_pkg::ECHO_W-1:0]    echo_cnt;
  logic [RW-1:0]                 round_idx;
  logic [uer_pkg::PROD_W-1:0]    prod;

  logic                          out_valid;
  logic                          out_trig;
  logic                          out_busy;
  logic                          out_done;
  logic [uer_pkg::DIST_W-1:0]    out_dist;
  uer_pkg::status_e              out_status;

  logic [uer_pkg::TICK_W:0]      tick_inc;
  logic [uer_pkg::TPC_W:0]       pre_inc;
  logic [RW:0]                   round_nx;
  logic [uer_pkg::DIST_W-1:0]    cm;
  logic                          in_range;
  logic                          fire;

  assign tick.ready = cw.fetch && !rst;

  assign tick_inc = {1'b0, tick_cnt} + (uer_pkg::TICK_W + 1)'(1);
  assign pre_inc  = {1'b0, pre_cnt} + (uer_pkg::TPC_W + 1)'(1);
  assign round_nx = {1'b0, round_idx} + (RW + 1)'(1);
  assign cm       = prod[uer_pkg::CM_SHIFT +: uer_pkg::DIST_W];
  assign in_range = (cm > regs.min_distance) && (cm <= regs.max_distance);

  always_comb begin
    flags.cmd        = cmd_q;
    flags.echo       = echo_q;
    flags.trig_end   = tick_inc >= (uer_pkg::TICK_W + 1)'(regs.trig_ticks);
    flags.timeout    = tick_inc > {1'b0, regs.timeout_ticks};
    flags.gap_zero   = regs.gap_ticks == '0;
    flags.gap_end    = tick_inc >= (uer_pkg::TICK_W + 1)'(regs.gap_ticks);
    flags.last_round = round_nx >= SAMPLES_V;
    flags.no_valid   = valid_cnt == '0;
    flags.div_more   = div_more;
    flags.hold       = (cw.fetch && !tick.valid) || (cw.emit && out_valid && !result.ready);
  end

  assign fire = !flags.hold;

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      cmd_q  <= tick.cmd;
      echo_q <= tick.echo;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      case (cw.tick_op)
        uer_pkg::TICK_CLR: tick_cnt <= '0;
        uer_pkg::TICK_INC: tick_cnt <= tick_inc[uer_pkg::TICK_W-1:0];
        default: ;
      endcase
      if (cw.meas_clr) begin
        pre_cnt  <= '0;
        echo_cnt <= '0;
      end else if (cw.pre_tick) begin
        if (pre_inc >= {1'b0, regs.ticks_per_count}) begin
          pre_cnt <= '0;
          if (echo_cnt != '1) begin
            echo_cnt <= echo_cnt + uer_pkg::ECHO_W'(1);
          end
        end else begin
          pre_cnt <= pre_inc[uer_pkg::TPC_W-1:0];
        end
      end
      if (cw.run_clr) begin
        round_idx <= '0;
        sum       <= '0;
        valid_cnt <= '0;
      end else begin
        if (cw.round_inc) begin
          round_idx <= round_nx[RW-1:0];
        end
        if (cw.acc_sample && in_range) begin
          sum       <= sum + SUM_W'(cm);
          valid_cnt <= valid_cnt + RW'(1);
        end
      end
      if (cw.mul_load) begin
        prod <= echo_cnt * uer_pkg::CM_MUL;
      end
    end
  end

  // result register: a new result may load as the previous one drains
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && cw.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && cw.emit) begin
      out_trig   <= cw.out_trig;
      out_busy   <= cw.out_busy;
      out_done   <= cw.out_done;
      out_status <= cw.out_status;
      out_dist   <= cw.out_dist ? quo[uer_pkg::DIST_W-1:0] : '0;
    end
  end

  assign result.valid    = out_valid;
  assign result.trigger  = out_trig;
  assign result.busy_res = out_busy;
  assign result.done_res = out_done;
  assign result.distance = out_dist;
  assign result.status   = out_status;

endmodule

// ----- design/ultrasonic_echo_ranger.sv -----
// Top level of the ultrasonic echo ranger.
//
//   channel  modport  transaction
//   -------  -------  ---------------------------------------------------
//   tick     sink     cmd, echo: one sensor tick per transaction
//   result   source   trigger, busy_res, done_res, distance, status
//   cfg      sink     index, data: one register write per transaction
//
// Each tick runs through a short microprogram at one control word per cycle while
// neither a tick fetch nor a result output stalls. The final tick adds the divide
// load and SUM_W restoring steps (17 at SAMPLES = 3).
// rst is synchronous; tick and cfg are not ready while it is high.
// A stalled result holds the sequencer only at its next output step.
module ultrasonic_echo_ranger #(
  parameter int SAMPLES = uer_pkg::SAMPLES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  uer_tick_if.sink     tick,
  uer_result_if.source result,
  uer_cfg_if.sink      cfg
);

  localparam int SUM_W = uer_pkg::DIST_W + $clog2(SAMPLES);
  localparam int RW    = $clog2(SAMPLES + 1);

  uer_pkg::cfg_t       regs;
  uer_pkg::ctrl_word_t cw;
  uer_pkg::flags_t     flags;
  logic [SUM_W-1:0]    sum;
  logic [RW-1:0]       valid_cnt;
  logic [SUM_W-1:0]    quo;
  logic                div_more;

  uer_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  uer_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cw    (cw)
  );

  uer_divider #(
    .NUM_W (SUM_W),
    .DEN_W (RW)
  ) u_div (
    .clk  (clk),
    .op   (cw.div_op),
    .num  (sum),
    .den  (valid_cnt),
    .quo  (quo),
    .more (div_more)
  );

  uer_datapath #(
    .SAMPLES (SAMPLES),
    .SUM_W   (SUM_W),
    .RW      (RW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .cw        (cw),
    .quo       (quo),
    .div_more  (div_more),
    .flags     (flags),
    .sum       (sum),
    .valid_cnt (valid_cnt),
    .tick      (tick),
    .result    (result)
  );

endmodule

// ----- design/uer_checker.sv -----
// Port-level checks on the ranger's result stream, bound to the top level.
module uer_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic                         trigger,
  input logic                         busy_res,
  input logic                         done_res,
  input logic [uer_pkg::DIST_W-1:0]   distance,
  input logic [uer_pkg::STATUS_W-1:0] status
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(distance) && $stable(status)
      && $stable(done_res) && $stable(busy_res) && $stable(trigger))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !res_valid)
    else $error("result valid straight after reset");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> !busy_res && !trigger)
    else $error("final result still busy or triggering");

  a_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && (!done_res || status != uer_pkg::STAT_OK) |-> distance == '0)
    else $error("distance reported without a good final result");

  a_status_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && !done_res |-> status == uer_pkg::STAT_OK)
    else $error("status set on a non-final result");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .trigger   (result.trigger),
  .busy_res  (result.busy_res),
  .done_res  (result.done_res),
  .distance  (result.distance),
  .status    (result.status)
);
